// ===== hdl/gdate_pkg.sv =====
package gdate_pkg;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int OFS_W  = 23;
    localparam int CNT_W  = 23;
    localparam int ST_W   = 2;
    // day serial of any date up to year 65535 (0 is 0001-01-01)
    localparam int SER_W  = 25;
    // year counter of the walk, holds up to 65535
    localparam int YC_W   = 16;

    localparam int MAX_YEAR_DEF = 9999;

    localparam logic [MON_W-1:0] MONTHS = MON_W'(12);

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_BAD_DATE,
        ST_RANGE
    } code_t;

    // year walk phases: 400, 100, 4 and 1 year blocks
    typedef enum logic [1:0] {
        PH_400,
        PH_100,
        PH_4,
        PH_1
    } ph_t;

    typedef enum logic [1:0] {
        PASS_A,
        PASS_B,
        PASS_INV
    } pass_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_Y400,
        S_Y100,
        S_Y4,
        S_Y1,
        S_MON,
        S_DAY,
        S_SAVE,
        S_RANGE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  sel_b;
        logic  start_fwd;
        logic  start_inv;
        logic  yrun;
        ph_t   ph;
        logic  mrun;
        logic  fix_day;
        logic  save_a;
        logic  emit;
        code_t code;
    } cmd_t;

    typedef struct packed {
        logic coarse_bad;
        logic y_go;
        logic m_go;
        logic day_bad;
        logic range_bad;
        logic diff_mode;
        logic out_free;
    } stat_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mo, input logic leap);
        logic [DAY_W-1:0] len;
        case (mo)
            MON_W'(2):  len = leap ? DAY_W'(29) : DAY_W'(28);
            MON_W'(4),
            MON_W'(6),
            MON_W'(9),
            MON_W'(11): len = DAY_W'(30);
            default:    len = DAY_W'(31);
        endcase
        return len;
    endfunction

    function automatic logic [8:0] ph_years(input ph_t ph);
        logic [8:0] y;
        case (ph)
            PH_400:  y = 9'd400;
            PH_100:  y = 9'd100;
            PH_4:    y = 9'd4;
            default: y = 9'd1;
        endcase
        return y;
    endfunction

    function automatic logic [17:0] ph_days(input ph_t ph);
        logic [17:0] d;
        case (ph)
            PH_400:  d = 18'd146097;
            PH_100:  d = 18'd36524;
            PH_4:    d = 18'd1461;
            default: d = 18'd365;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/gdate_dp.sv =====
module gdate_dp #(
    parameter int unsigned MAX_YEAR = gdate_pkg::MAX_YEAR_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gdate_pkg::cmd_t                    cmd,
    output gdate_pkg::stat_t                   st,
    input  logic                               func,
    input  logic [gdate_pkg::YEAR_W-1:0]       year_a,
    input  logic [gdate_pkg::MON_W-1:0]        month_a,
    input  logic [gdate_pkg::DAY_W-1:0]        day_a,
    input  logic signed [gdate_pkg::OFS_W-1:0] offset_days,
    input  logic [gdate_pkg::YEAR_W-1:0]       year_b,
    input  logic [gdate_pkg::MON_W-1:0]        month_b,
    input  logic [gdate_pkg::DAY_W-1:0]        day_b,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [gdate_pkg::YEAR_W-1:0]       res_year,
    output logic [gdate_pkg::MON_W-1:0]        res_month,
    output logic [gdate_pkg::DAY_W-1:0]        res_day,
    output logic signed [gdate_pkg::CNT_W-1:0] day_count,
    output logic [gdate_pkg::ST_W-1:0]         status
);
    import gdate_pkg::*;

    // serial of the last day of MAX_YEAR
    localparam int unsigned LAST_INT =
        MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1;
    localparam logic [SER_W-1:0] LAST_SER = SER_W'(LAST_INT);
    localparam logic [YC_W:0]    MAXY     = (YC_W+1)'(MAX_YEAR);

    logic                    func_reg;
    logic [YEAR_W-1:0]       ya_reg, yb_reg;
    logic [MON_W-1:0]        ma_reg, mb_reg;
    logic [DAY_W-1:0]        da_reg, db_reg;
    logic signed [OFS_W-1:0] ofs_reg;

    logic              inv_reg, inv_next;
    logic [YC_W-1:0]   ycnt_reg, ycnt_next;
    logic [SER_W-1:0]  dcnt_reg, dcnt_next;
    logic [SER_W-1:0]  sa_reg, sa_next;
    logic [1:0]        q100_reg, q100_next;
    logic [4:0]        q4_reg, q4_next;
    logic [1:0]        q1_reg, q1_next;
    logic [MON_W-1:0]  mo_reg, mo_next;

    logic                    out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]       res_year_reg, res_year_next;
    logic [MON_W-1:0]        res_month_reg, res_month_next;
    logic [DAY_W-1:0]        res_day_reg, res_day_next;
    logic signed [CNT_W-1:0] day_count_reg, day_count_next;
    logic [ST_W-1:0]         status_reg, status_next;

    logic [YEAR_W-1:0]       cur_y;
    logic [MON_W-1:0]        cur_m;
    logic [DAY_W-1:0]        cur_d;
    logic                    leap;
    logic [DAY_W-1:0]        ml;
    logic [8:0]              yu;
    logic [17:0]             yd;
    logic                    cap_ok;
    logic signed [SER_W:0]   sum_s;
    logic signed [SER_W:0]   diff_s;
    logic                    diff_fits;
    logic [YC_W-1:0]         ycnt_p1;
    logic                    out_load;

    assign cur_y = cmd.sel_b ? yb_reg : ya_reg;
    assign cur_m = cmd.sel_b ? mb_reg : ma_reg;
    assign cur_d = cmd.sel_b ? db_reg : da_reg;

    // year is leap when it is the last of a 4-year block, unless that block
    // closes a century that is not the last of its 400-year block
    assign leap = (q1_reg == 2'd3) && ((q4_reg != 5'd24) || (q100_reg == 2'd3));
    assign ml   = month_len(mo_reg, leap);
    assign yu   = ph_years(cmd.ph);
    assign yd   = ph_days(cmd.ph);

    always_comb
    begin
        case (cmd.ph)
            PH_100:  cap_ok = (q100_reg != 2'd3);
            PH_1:    cap_ok = (q1_reg != 2'd3);
            default: cap_ok = 1'b1;
        endcase
    end

    assign sum_s  = $signed({1'b0, dcnt_reg})
                  + $signed({{(SER_W + 1 - OFS_W){ofs_reg[OFS_W-1]}}, ofs_reg});
    assign diff_s = $signed({1'b0, sa_reg}) - $signed({1'b0, dcnt_reg});
    assign diff_fits = (&diff_s[SER_W:CNT_W-1]) | ~(|diff_s[SER_W:CNT_W-1]);
    assign ycnt_p1 = ycnt_reg + YC_W'(1);

    always_comb
    begin
        st.coarse_bad = (cur_y == '0) || ((YC_W+1)'(cur_y) > MAXY)
                     || (cur_m == '0) || (cur_m > MONTHS) || (cur_d == '0);
        st.y_go       = cap_ok && (inv_reg ? (dcnt_reg >= SER_W'(yd))
                                           : (ycnt_reg >= YC_W'(yu)));
        st.m_go       = inv_reg ? ((mo_reg < MONTHS) && (dcnt_reg >= SER_W'(ml)))
                                : (mo_reg < cur_m);
        st.day_bad    = (cur_d > ml);
        st.range_bad  = func_reg ? !diff_fits
                                 : (sum_s[SER_W] || (sum_s > $signed({1'b0, LAST_SER})));
        st.diff_mode  = func_reg;
        st.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_load = cmd.emit && st.out_free;

    // walk registers
    always_comb
    begin
        inv_next  = inv_reg;
        ycnt_next = ycnt_reg;
        dcnt_next = dcnt_reg;
        sa_next   = sa_reg;
        q100_next = q100_reg;
        q4_next   = q4_reg;
        q1_next   = q1_reg;
        mo_next   = mo_reg;
        if (cmd.start_fwd)
        begin
            inv_next  = 1'b0;
            ycnt_next = {{(YC_W - YEAR_W){1'b0}}, cur_y} - YC_W'(1);
            dcnt_next = '0;
            q100_next = '0;
            q4_next   = '0;
            q1_next   = '0;
            mo_next   = MON_W'(1);
        end
        else if (cmd.start_inv)
        begin
            inv_next  = 1'b1;
            ycnt_next = '0;
            dcnt_next = sum_s[SER_W-1:0];
            q100_next = '0;
            q4_next   = '0;
            q1_next   = '0;
            mo_next   = MON_W'(1);
        end
        else if (cmd.yrun && st.y_go)
        begin
            if (inv_reg)
            begin
                ycnt_next = ycnt_reg + YC_W'(yu);
                dcnt_next = dcnt_reg - SER_W'(yd);
            end
            else
            begin
                ycnt_next = ycnt_reg - YC_W'(yu);
                dcnt_next = dcnt_reg + SER_W'(yd);
            end
            case (cmd.ph)
                PH_100:  q100_next = q100_reg + 2'd1;
                PH_4:    q4_next   = q4_reg + 5'd1;
                PH_1:    q1_next   = q1_reg + 2'd1;
                default: q100_next = q100_reg;
            endcase
        end
        else if (cmd.mrun && st.m_go)
        begin
            dcnt_next = inv_reg ? (dcnt_reg - SER_W'(ml)) : (dcnt_reg + SER_W'(ml));
            mo_next   = mo_reg + MON_W'(1);
        end
        else if (cmd.fix_day)
        begin
            dcnt_next = dcnt_reg + SER_W'(cur_d) - SER_W'(1);
        end
        else if (cmd.save_a)
        begin
            sa_next = dcnt_reg;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_year_next  = res_year_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        day_count_next = day_count_reg;
        status_next    = status_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            res_year_next  = '0;
            res_month_next = '0;
            res_day_next   = '0;
            day_count_next = '0;
            status_next    = cmd.code;
            if (cmd.code == ST_OK)
            begin
                if (func_reg)
                begin
                    day_count_next = diff_s[CNT_W-1:0];
                end
                else
                begin
                    res_year_next  = ycnt_p1[YEAR_W-1:0];
                    res_month_next = mo_reg;
                    res_day_next   = dcnt_reg[DAY_W-1:0] + DAY_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            ya_reg   <= year_a;
            ma_reg   <= month_a;
            da_reg   <= day_a;
            ofs_reg  <= offset_days;
            yb_reg   <= year_b;
            mb_reg   <= month_b;
            db_reg   <= day_b;
        end
        inv_reg       <= inv_next;
        ycnt_reg      <= ycnt_next;
        dcnt_reg      <= dcnt_next;
        sa_reg        <= sa_next;
        q100_reg      <= q100_next;
        q4_reg        <= q4_next;
        q1_reg        <= q1_next;
        mo_reg        <= mo_next;
        res_year_reg  <= res_year_next;
        res_month_reg <= res_month_next;
        res_day_reg   <= res_day_next;
        day_count_reg <= day_count_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign res_year  = res_year_reg;
    assign res_month = res_month_reg;
    assign res_day   = res_day_reg;
    assign day_count = day_count_reg;
    assign status    = status_reg;

    // forward walk has used up every year before the day is added
    a_fwd_years_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fix_day |-> ycnt_reg == '0)
        else $error("year count left over at end of forward walk");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && cmd.code != ST_OK |=>
        res_year == '0 && res_month == '0 && res_day == '0 && day_count == '0)
        else $error("error item carries nonzero result");

    a_add_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && cmd.code == ST_OK && !func_reg |=>
        res_month != '0 && res_month <= MONTHS && res_day != '0)
        else $error("offset result is not a calendar date");

endmodule

// ===== hdl/gdate_ctrl.sv =====
module gdate_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  gdate_pkg::stat_t st,
    output gdate_pkg::cmd_t  cmd
);
    import gdate_pkg::*;

    state_t state_reg, state_next;
    pass_t  sel_reg, sel_next;
    code_t  code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                    sel_next   = PASS_A;
                    code_next  = ST_OK;
                end
            end
            S_CHECK:
            begin
                if (st.coarse_bad)
                begin
                    state_next = S_EMIT;
                    code_next  = ST_BAD_DATE;
                end
                else
                begin
                    state_next = S_Y400;
                end
            end
            S_Y400: if (!st.y_go) state_next = S_Y100;
            S_Y100: if (!st.y_go) state_next = S_Y4;
            S_Y4:   if (!st.y_go) state_next = S_Y1;
            S_Y1:   if (!st.y_go) state_next = S_MON;
            S_MON:
            begin
                if (!st.m_go)
                begin
                    state_next = (sel_reg == PASS_INV) ? S_EMIT : S_DAY;
                end
            end
            S_DAY:
            begin
                if (st.day_bad)
                begin
                    state_next = S_EMIT;
                    code_next  = ST_BAD_DATE;
                end
                else if (st.diff_mode && sel_reg == PASS_A)
                begin
                    state_next = S_SAVE;
                end
                else
                begin
                    state_next = S_RANGE;
                end
            end
            S_SAVE:
            begin
                state_next = S_CHECK;
                sel_next   = PASS_B;
            end
            S_RANGE:
            begin
                if (st.range_bad)
                begin
                    state_next = S_EMIT;
                    code_next  = ST_RANGE;
                end
                else if (st.diff_mode)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_Y400;
                    sel_next   = PASS_INV;
                end
            end
            S_EMIT: if (st.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.ph        = PH_400;
        cmd.code      = code_reg;
        cmd.sel_b     = (sel_reg == PASS_B);
        in_stall      = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:  cmd.capture   = in_valid;
            S_CHECK: cmd.start_fwd = 1'b1;
            S_Y400:
            begin
                cmd.yrun = 1'b1;
                cmd.ph   = PH_400;
            end
            S_Y100:
            begin
                cmd.yrun = 1'b1;
                cmd.ph   = PH_100;
            end
            S_Y4:
            begin
                cmd.yrun = 1'b1;
                cmd.ph   = PH_4;
            end
            S_Y1:
            begin
                cmd.yrun = 1'b1;
                cmd.ph   = PH_1;
            end
            S_MON:   cmd.mrun      = 1'b1;
            S_DAY:   cmd.fix_day   = 1'b1;
            S_SAVE:  cmd.save_a    = 1'b1;
            S_RANGE: cmd.start_inv = !st.diff_mode;
            S_EMIT:  cmd.emit      = 1'b1;
            default: cmd.emit      = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= PASS_A;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            code_reg  <= code_next;
        end
    end

    // date walk back from a serial only happens for the offset function
    a_inv_add_only: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg == PASS_INV |-> !st.diff_mode)
        else $error("inverse walk entered for difference item");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=>
        state_reg == S_CHECK && sel_reg == PASS_A && code_reg == ST_OK)
        else $error("accepted item did not start on date A");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && !st.out_free |=> state_reg == S_EMIT)
        else $error("result left emit state while output register full");

endmodule

// ===== hdl/gregorian_date_offset_and_difference_top.sv =====
// An item whose fields fail the coarse range checks goes from the check state straight to emit;
// otherwise the controller walks years in 400, 100, 4 and 1 year phases and then months to turn
// a date into a day serial, and for the offset function walks again to turn the serial back
// into a date. A stalled output register holds the controller in its emit state.
// Throughput: one item at a time; the next item is accepted in the cycle after the result
// is loaded into the output register. Reset clears the controller and output valid.
module gregorian_date_offset_and_difference_top #(
    parameter int unsigned MAX_YEAR = gdate_pkg::MAX_YEAR_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [gdate_pkg::YEAR_W-1:0]       year_a,
    input  logic [gdate_pkg::MON_W-1:0]        month_a,
    input  logic [gdate_pkg::DAY_W-1:0]        day_a,
    input  logic signed [gdate_pkg::OFS_W-1:0] offset_days,
    input  logic [gdate_pkg::YEAR_W-1:0]       year_b,
    input  logic [gdate_pkg::MON_W-1:0]        month_b,
    input  logic [gdate_pkg::DAY_W-1:0]        day_b,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gdate_pkg::YEAR_W-1:0]       res_year,
    output logic [gdate_pkg::MON_W-1:0]        res_month,
    output logic [gdate_pkg::DAY_W-1:0]        res_day,
    output logic signed [gdate_pkg::CNT_W-1:0] day_count,
    output logic [gdate_pkg::ST_W-1:0]         status
);
    import gdate_pkg::*;

    cmd_t  cmd;
    stat_t st;

    gdate_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    gdate_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .func        (func),
        .year_a      (year_a),
        .month_a     (month_a),
        .day_a       (day_a),
        .offset_days (offset_days),
        .year_b      (year_b),
        .month_b     (month_b),
        .day_b       (day_b),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .res_year    (res_year),
        .res_month   (res_month),
        .res_day     (res_day),
        .day_count   (day_count),
        .status      (status)
    );

endmodule
